>>> rtl/core/bcf_pkg.sv
// Shared types and constants of the box clearance field core.
`default_nettype none

package bcf_pkg;

	// Item kinds carried in the queue
	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_BOX  = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	// Configuration register indexes
	localparam logic [2:0] REG_X_ORIGIN = 3'd0;
	localparam logic [2:0] REG_X_STEP   = 3'd1;
	localparam logic [2:0] REG_Y_ORIGIN = 3'd2;
	localparam logic [2:0] REG_Y_STEP   = 3'd3;
	localparam logic [2:0] REG_COLUMNS  = 3'd4;
	localparam logic [2:0] REG_ROWS     = 3'd5;
	localparam logic [2:0] REG_MARGIN   = 3'd6;

	localparam int QUEUE_DEPTH = 4;
	// Width of window bound numerators and quotients
	localparam int NUM_W = 36;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = -32'sh7fffffff - 32'sh1;

	typedef struct packed {
		cmd_t               cmd;
		logic [7:0]         row;
		logic [7:0]         col;
		logic signed [31:0] value;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        hw;
		logic [30:0]        hh;
		logic signed [31:0] base;
		logic signed [31:0] rate;
		logic [15:0]        frame;
	} item_t;

	typedef struct packed {
		logic signed [31:0] x_origin;
		logic [30:0]        x_step;
		logic signed [31:0] y_origin;
		logic [30:0]        y_step;
		logic [8:0]         columns;
		logic [8:0]         rows;
		logic [30:0]        margin;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic [7:0]         col;
		logic [7:0]         row;
		logic signed [31:0] value;
	} result_t;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(SAT_MAX)) r = SAT_MAX;
		else if (v < 64'(SAT_MIN)) r = SAT_MIN;
		else r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bcf_queue.sv
// Short item queue between the front and the back of the core.
`default_nettype none

module bcf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bcf_pkg::item_t push_item,
	input  wire logic           pop,
	output bcf_pkg::item_t      head,
	output bcf_pkg::qstat_t     stat
);
	import bcf_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam logic [PW:0] DEPTH_C = (PW + 1)'(QUEUE_DEPTH);

	item_t         slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign head       = slots_q[rd_ptr_q];
	assign stat.full  = (count_q == DEPTH_C);
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

>>> rtl/core/bcf_div.sv
// Iterative signed-by-positive divider with floor or ceil rounding.
`default_nettype none

module bcf_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [bcf_pkg::NUM_W-1:0] num,
	input  wire logic [30:0]                      den,
	input  wire logic                             ceil_mode,
	output logic                                  done,
	output logic signed [bcf_pkg::NUM_W-1:0]      quo
);
	import bcf_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q;
	logic [31:0]      rem_q;
	logic [30:0]      den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             ceil_q;
	logic             busy_q;
	logic             done_q;

	logic [NUM_W-1:0] num_abs;
	logic [31:0]      rem_sh;
	logic             ge;
	logic             inexact;
	logic signed [NUM_W-1:0] mag_s;

	assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign rem_sh  = {rem_q[30:0], mag_q[NUM_W-1]};
	assign ge      = (rem_sh >= {1'b0, den_q});

	// One quotient bit per cycle, restoring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mag_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			neg_q  <= 1'b0;
			ceil_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				mag_q  <= num_abs;
				rem_q  <= '0;
				den_q  <= den;
				neg_q  <= num[NUM_W-1];
				ceil_q <= ceil_mode;
			end else if (busy_q) begin
				mag_q <= {mag_q[NUM_W-2:0], ge};
				rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Rounding from magnitude, sign and remainder
	assign inexact = (rem_q != '0);
	assign mag_s   = signed'(mag_q);
	always_comb begin
		if (ceil_q) quo = neg_q ? -mag_s : mag_s + NUM_W'(inexact);
		else        quo = neg_q ? -mag_s - NUM_W'(inexact) : mag_s;
	end

	assign done = done_q;

endmodule

`default_nettype wire

>>> rtl/core/bcf_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none

module bcf_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);
	localparam int STEPS = 32;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [63:0]      rad_q;
	logic [34:0]      rem_q;
	logic [31:0]      root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [34:0] rem_sh;
	logic [34:0] trial;
	logic        ge;

	assign rem_sh = {rem_q[32:0], rad_q[63:62]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	// One root bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rad_q  <= {rad_q[61:0], 2'b00};
				rem_q  <= ge ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[30:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

>>> rtl/core/bcf_back.sv
// Back end: grid memory, load/read handling and the box window walk.
`default_nettype none

module bcf_back #(
	parameter int MAX_ROWS    = 256,
	parameter int MAX_COLUMNS = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bcf_pkg::cfg_t   cfg,
	input  wire bcf_pkg::item_t  head,
	input  wire bcf_pkg::qstat_t qstat,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bcf_pkg::result_t     result
);
	import bcf_pkg::*;

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int AW = $clog2(MAX_ROWS * MAX_COLUMNS);
	localparam int WW = ((RW > CW) ? RW : CW) + 36;
	localparam logic [AW-1:0] COLS_A = AW'(MAX_COLUMNS);

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_OUT, ST_UNC_MUL, ST_UNC_ADD, ST_HALF, ST_DIV_GO, ST_DIV_WAIT,
		ST_CLAMP, ST_ROW_MUL, ST_ROW_D, ST_CELL_MUL, ST_CELL_D, ST_CELL_SEL, ST_SQX,
		ST_SQY, ST_SQRT_GO, ST_SQRT_WAIT, ST_CELL_WR
	} state_t;

	state_t state_q;

	// Grid memory
	logic signed [31:0] grid_mem [MAX_ROWS * MAX_COLUMNS];
	logic signed [31:0] rd_q;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic signed [31:0] mem_wd;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;

	// Datapath registers
	logic signed [31:0]      peak_q;
	logic signed [48:0]      prod_q;
	logic signed [31:0]      unc_q;
	logic signed [31:0]      ohw_q;
	logic signed [31:0]      ohh_q;
	logic [1:0]              div_idx_q;
	logic signed [NUM_W-1:0] c0_q, c1_q, r0_q, r1_q;
	logic [CW-1:0]           col_lo_q, col_hi_q, c_q;
	logic [RW-1:0]           row_hi_q, r_q;
	logic [RW+30:0]          prod_y_q;
	logic [CW+30:0]          prod_x_q;
	logic signed [WW-1:0]    dy_q, dx_q;
	logic [30:0]             ex_q, ey_q;
	logic [61:0]             sq_q, sqy_q;
	logic signed [31:0]      val_q;
	logic                    out_valid_q;
	result_t                 result_q;

	// Combinational helpers
	logic                    head_in;
	logic [AW-1:0]           head_addr, cell_addr;
	logic [30:0]             xs, ys;
	logic [CW-1:0]           col_last;
	logic [RW-1:0]           row_last;
	logic signed [31:0]      imp;
	logic signed [NUM_W-1:0] div_num, div_quo;
	logic [30:0]             div_den;
	logic                    div_start, div_done;
	logic signed [NUM_W-1:0] lo_c, hi_c, lo_r, hi_r;
	logic                    win_empty;
	logic signed [WW-1:0]    sy, ay, dy_next, sx, ax, dx_next, dmax;
	logic                    sqrt_start, sqrt_done;
	logic [31:0]             sqrt_root;
	logic                    slot_free;
	logic                    last_cell;

	assign head_in   = (int'(head.row) < MAX_ROWS) && (int'(head.col) < MAX_COLUMNS);
	assign head_addr = AW'(head.row) * COLS_A + AW'(head.col);
	assign cell_addr = AW'(r_q) * COLS_A + AW'(c_q);
	assign xs        = (cfg.x_step == '0) ? 31'd1 : cfg.x_step;
	assign ys        = (cfg.y_step == '0) ? 31'd1 : cfg.y_step;
	assign imp       = (peak_q > 32'sd0) ? peak_q : 32'sd0;
	assign slot_free = !out_valid_q || out_ready;
	assign last_cell = (c_q == col_hi_q) && (r_q == row_hi_q);

	// Grid size in use, saturated into the storage
	always_comb begin
		if (cfg.columns < 9'd2) col_last = CW'(1);
		else if (int'(cfg.columns) > MAX_COLUMNS) col_last = CW'(MAX_COLUMNS - 1);
		else col_last = CW'(cfg.columns - 9'd1);
		if (cfg.rows < 9'd2) row_last = RW'(1);
		else if (int'(cfg.rows) > MAX_ROWS) row_last = RW'(MAX_ROWS - 1);
		else row_last = RW'(cfg.rows - 9'd1);
	end

	// Window bound numerators: low x, high x, low y, high y
	always_comb begin
		case (div_idx_q)
			2'd0: div_num = NUM_W'(head.cx) - NUM_W'(ohw_q) - NUM_W'(imp)
				- NUM_W'(cfg.x_origin);
			2'd1: div_num = NUM_W'(head.cx) + NUM_W'(ohw_q) + NUM_W'(imp)
				- NUM_W'(cfg.x_origin);
			2'd2: div_num = NUM_W'(head.cy) - NUM_W'(ohh_q) - NUM_W'(imp)
				- NUM_W'(cfg.y_origin);
			default: div_num = NUM_W'(head.cy) + NUM_W'(ohh_q) + NUM_W'(imp)
				- NUM_W'(cfg.y_origin);
		endcase
	end
	assign div_den   = div_idx_q[1] ? ys : xs;
	assign div_start = (state_q == ST_DIV_GO);

	bcf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.num       (div_num),
		.den       (div_den),
		.ceil_mode (div_idx_q[0]),
		.done      (div_done),
		.quo       (div_quo)
	);

	// Clamp the window to the grid in use
	assign lo_c = (c0_q < 0) ? '0 : c0_q;
	assign hi_c = (c1_q > signed'(NUM_W'(col_last))) ? signed'(NUM_W'(col_last)) : c1_q;
	assign lo_r = (r0_q < 0) ? '0 : r0_q;
	assign hi_r = (r1_q > signed'(NUM_W'(row_last))) ? signed'(NUM_W'(row_last)) : r1_q;
	assign win_empty = (lo_c > hi_c) || (lo_r > hi_r);

	// Axis distances to the grown box
	assign sy      = WW'(cfg.y_origin) + signed'(WW'(prod_y_q));
	assign ay      = sy - WW'(head.cy);
	assign dy_next = ((ay < 0) ? -ay : ay) - WW'(ohh_q);
	assign sx      = WW'(cfg.x_origin) + signed'(WW'(prod_x_q));
	assign ax      = sx - WW'(head.cx);
	assign dx_next = ((ax < 0) ? -ax : ax) - WW'(ohw_q);
	assign dmax    = (dx_q > dy_q) ? dx_q : dy_q;

	assign sqrt_start = (state_q == ST_SQRT_GO);

	bcf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (64'(sq_q) + 64'(sqy_q)),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Memory port control
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = cell_addr;
		mem_wd  = val_q;
		rd_en   = 1'b0;
		rd_addr = cell_addr;
		pop     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mem_wa  = head_addr;
				mem_wd  = head.value;
				rd_addr = head_addr;
				if (!qstat.empty) begin
					if (head.cmd == CMD_LOAD) begin
						mem_we = head_in;
						pop    = 1'b1;
					end else if (head.cmd == CMD_READ) begin
						rd_en = 1'b1;
					end
				end
			end
			ST_RD_OUT:   pop = slot_free;
			ST_CLAMP:    pop = win_empty;
			ST_CELL_MUL: rd_en = 1'b1;
			ST_CELL_WR: begin
				mem_we = (val_q < rd_q);
				pop    = last_cell;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= grid_mem[rd_addr];
	end

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			peak_q      <= SAT_MIN;
			out_valid_q <= 1'b0;
			result_q    <= '0;
			prod_q      <= '0;
			unc_q       <= '0;
			ohw_q       <= '0;
			ohh_q       <= '0;
			div_idx_q   <= '0;
			c0_q        <= '0;
			c1_q        <= '0;
			r0_q        <= '0;
			r1_q        <= '0;
			col_lo_q    <= '0;
			col_hi_q    <= '0;
			row_hi_q    <= '0;
			c_q         <= '0;
			r_q         <= '0;
			prod_y_q    <= '0;
			prod_x_q    <= '0;
			dy_q        <= '0;
			dx_q        <= '0;
			ex_q        <= '0;
			ey_q        <= '0;
			sq_q        <= '0;
			sqy_q       <= '0;
			val_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						case (head.cmd)
							CMD_LOAD: begin
								if (head_in && head.value > peak_q) peak_q <= head.value;
							end
							CMD_BOX:  state_q <= ST_UNC_MUL;
							CMD_READ: state_q <= ST_RD_OUT;
							default: ;
						endcase
					end
				end
				ST_RD_OUT: begin
					if (slot_free) begin
						out_valid_q    <= 1'b1;
						result_q.value <= head_in ? rd_q : 32'sd0;
						result_q.row   <= head.row;
						result_q.col   <= head.col;
						state_q        <= ST_IDLE;
					end
				end
				ST_UNC_MUL: begin
					prod_q  <= signed'({1'b0, head.frame}) * head.rate;
					state_q <= ST_UNC_ADD;
				end
				ST_UNC_ADD: begin
					unc_q   <= sat32(64'(prod_q) + 64'(head.base));
					state_q <= ST_HALF;
				end
				ST_HALF: begin
					ohw_q <= sat32(signed'(64'(cfg.margin)) + signed'(64'(head.hw))
						+ 64'(unc_q));
					ohh_q <= sat32(signed'(64'(cfg.margin)) + signed'(64'(head.hh))
						+ 64'(unc_q));
					div_idx_q <= 2'd0;
					state_q   <= ST_DIV_GO;
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						case (div_idx_q)
							2'd0:    c0_q <= div_quo;
							2'd1:    c1_q <= div_quo;
							2'd2:    r0_q <= div_quo;
							default: r1_q <= div_quo;
						endcase
						if (div_idx_q == 2'd3) begin
							state_q <= ST_CLAMP;
						end else begin
							div_idx_q <= div_idx_q + 2'd1;
							state_q   <= ST_DIV_GO;
						end
					end
				end
				ST_CLAMP: begin
					if (win_empty) begin
						state_q <= ST_IDLE;
					end else begin
						col_lo_q <= CW'(lo_c);
						col_hi_q <= CW'(hi_c);
						row_hi_q <= RW'(hi_r);
						r_q      <= RW'(lo_r);
						state_q  <= ST_ROW_MUL;
					end
				end
				ST_ROW_MUL: begin
					prod_y_q <= (RW + 31)'(r_q) * (RW + 31)'(ys);
					state_q  <= ST_ROW_D;
				end
				ST_ROW_D: begin
					dy_q    <= dy_next;
					c_q     <= col_lo_q;
					state_q <= ST_CELL_MUL;
				end
				ST_CELL_MUL: begin
					prod_x_q <= (CW + 31)'(c_q) * (CW + 31)'(xs);
					state_q  <= ST_CELL_D;
				end
				ST_CELL_D: begin
					dx_q    <= dx_next;
					state_q <= ST_CELL_SEL;
				end
				ST_CELL_SEL: begin
					if (dx_q <= 0 && dy_q <= 0) begin
						val_q   <= sat32(64'(dmax));
						state_q <= ST_CELL_WR;
					end else begin
						// Clip each term to the positive 32-bit range
						if (dx_q <= 0) ex_q <= '0;
						else if (dx_q > WW'(SAT_MAX)) ex_q <= '1;
						else ex_q <= dx_q[30:0];
						if (dy_q <= 0) ey_q <= '0;
						else if (dy_q > WW'(SAT_MAX)) ey_q <= '1;
						else ey_q <= dy_q[30:0];
						state_q <= ST_SQX;
					end
				end
				ST_SQX: begin
					sq_q    <= 62'(ex_q) * 62'(ex_q);
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					sqy_q   <= 62'(ey_q) * 62'(ey_q);
					state_q <= ST_SQRT_GO;
				end
				ST_SQRT_GO: state_q <= ST_SQRT_WAIT;
				ST_SQRT_WAIT: begin
					if (sqrt_done) begin
						val_q   <= (sqrt_root > 32'h7fffffff) ? SAT_MAX : signed'(sqrt_root);
						state_q <= ST_CELL_WR;
					end
				end
				ST_CELL_WR: begin
					if (last_cell) begin
						state_q <= ST_IDLE;
					end else if (c_q == col_hi_q) begin
						r_q     <= r_q + 1'b1;
						state_q <= ST_ROW_MUL;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= ST_CELL_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

`default_nettype wire

>>> rtl/core/box_clearance_field_min_core.sv
// Top level of the box clearance field core: front end, queue and back end.
//
// Input stream s_*: one transaction per command. s_tuser holds the command
// (load cell, apply box, read cell); other codes are dropped at the front.
// Output stream m_*: one transaction per read, carrying the stored value
// and the cell coordinates. Configuration is written through cfg_we,
// cfg_index and cfg_data while the core is idle.
// The front accepts into a four-entry queue whenever it has room, so items
// keep arriving while the back is busy or a result waits on m_tready.
// In the back a load retires from idle; a read passes through idle and the
// output state, where it waits out any output stall. A box runs a setup
// (uncertainty, half sizes, four 36-step divisions for the window bounds,
// clamp), then per window row the row product and distance and per cell the
// column product, distance and select, plus a 32-step square root when the
// sample point lies outside the grown box, and the cell write.
// Reset clears the queue, the peak of loaded values and the registers to
// their defaults; grid contents are undefined until loaded.
// When m_tready is low a finished read result holds in the output
// register and the back stops at the next read until it is taken.
`default_nettype none

module box_clearance_field_min_core #(
	parameter int MAX_ROWS      = 256,
	parameter int MAX_COLUMNS   = 256,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// row[7:0], column[15:8], cell_value[47:16], box_center_x[79:48],
	// box_center_y[111:80], box_half_width[142:112], box_half_height[173:143],
	// base_uncertainty[205:174], uncertainty_rate[237:206],
	// frame_number[253:238], zero pad[255:254]
	input  wire logic [255:0] s_tdata,
	// command[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// clearance_value[31:0], out_row[39:32], out_column[47:40]
	output logic [47:0]       m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import bcf_pkg::*;

	cfg_t    cfg_q;
	item_t   in_item;
	item_t   head;
	qstat_t  qstat;
	result_t result;
	logic    known_cmd;
	logic    push;
	logic    pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin <= '0;
			cfg_q.x_step   <= 31'(1) << FRACTION_BITS;
			cfg_q.y_origin <= '0;
			cfg_q.y_step   <= 31'(1) << FRACTION_BITS;
			cfg_q.columns  <= 9'd256;
			cfg_q.rows     <= 9'd256;
			cfg_q.margin   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_ORIGIN: cfg_q.x_origin <= signed'(cfg_data);
				REG_X_STEP:   cfg_q.x_step   <= cfg_data[30:0];
				REG_Y_ORIGIN: cfg_q.y_origin <= signed'(cfg_data);
				REG_Y_STEP:   cfg_q.y_step   <= cfg_data[30:0];
				REG_COLUMNS:  cfg_q.columns  <= cfg_data[8:0];
				REG_ROWS:     cfg_q.rows     <= cfg_data[8:0];
				REG_MARGIN:   cfg_q.margin   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Front: unpack and classify, drop unknown commands
	assign in_item.cmd   = cmd_t'(s_tuser);
	assign in_item.row   = s_tdata[7:0];
	assign in_item.col   = s_tdata[15:8];
	assign in_item.value = signed'(s_tdata[47:16]);
	assign in_item.cx    = signed'(s_tdata[79:48]);
	assign in_item.cy    = signed'(s_tdata[111:80]);
	assign in_item.hw    = s_tdata[142:112];
	assign in_item.hh    = s_tdata[173:143];
	assign in_item.base  = signed'(s_tdata[205:174]);
	assign in_item.rate  = signed'(s_tdata[237:206]);
	assign in_item.frame = s_tdata[253:238];

	assign known_cmd = (s_tuser == CMD_LOAD) || (s_tuser == CMD_BOX) || (s_tuser == CMD_READ);
	assign s_tready  = !qstat.full;
	assign push      = s_tvalid && s_tready && known_cmd;

	bcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (in_item),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	bcf_back #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tdata = {result.col, result.row, result.value};

	// A queued transaction is visible to the back on the next cycle
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !qstat.empty)
		else $error("queue empty after push");

	// The back never retires an item that is not there
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	// A result appears only when a read item retires
	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(pop))
		else $error("result without retired read");

endmodule

`default_nettype wire
